FILE: sv/bitmap_block_allocator_macros.svh
// Assertion helpers for the block allocator.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define BBA_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bba_pkg.sv
package bba_pkg;

  localparam int BYTES_W  = 20;
  localparam int BS_W     = 13;
  localparam int IDX_W    = 10;
  localparam int NEED_W   = 7;
  localparam int BS_MAX   = 4096;
  localparam int BS_RESET = 64;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_TOO_LARGE = 2'd2
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [NEED_W-1:0]   needed;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_CHECK,
    F_COUNT,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_EMIT
  } back_state_t;

endpackage

FILE: sv/bba_front.sv
module bba_front import bba_pkg::*; #(
  parameter int NUM_BLOCKS             = 1024,
  parameter int MAX_BLOCKS_PER_REQUEST = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [BYTES_W-1:0] request_bytes,
  input  logic               cfg_we,
  input  logic [BS_W-1:0]    cfg_data,
  input  logic               q_full,
  output logic               q_push,
  output job_t               q_data
);

  localparam int FCW = $clog2(NUM_BLOCKS + 1);
  localparam int PW  = FCW + BS_W;
  localparam int KW  = $clog2(MAX_BLOCKS_PER_REQUEST);
  localparam int AW  = BYTES_W + 1;

  front_state_t state, state_next;

  logic [BS_W-1:0]    blk_bytes;
  logic [BS_W-1:0]    bs_eff;
  logic [BS_W-1:0]    bs;
  logic [BYTES_W-1:0] bytes;
  logic [FCW-1:0]     free_count;
  logic [PW-1:0]      prod;
  logic [AW-1:0]      acc;
  logic [KW-1:0]      k;
  job_t               job;
  logic               room;
  logic               covered;
  logic               at_limit;

  always_comb begin
    if (blk_bytes == '0) begin
      bs_eff = BS_W'(1);
    end else if (blk_bytes > BS_W'(BS_MAX)) begin
      bs_eff = BS_W'(BS_MAX);
    end else begin
      bs_eff = blk_bytes;
    end
  end

  assign room     = 32'(prod) >= (32'(bytes) + 32'(bs));
  assign covered  = acc >= AW'(bytes);
  assign at_limit = k == KW'(MAX_BLOCKS_PER_REQUEST - 1);

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:  if (start) state_next = F_MUL;
      F_MUL:   state_next = F_CHECK;
      F_CHECK: state_next = room ? F_COUNT : F_PUSH;
      F_COUNT: if (covered || at_limit) state_next = F_PUSH;
      F_PUSH:  if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    busy   = state != F_IDLE;
    q_push = (state == F_PUSH) && !q_full;
    q_data = job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      blk_bytes  <= BS_W'(BS_RESET);
      free_count <= FCW'(NUM_BLOCKS);
    end else begin
      state <= state_next;
      if (cfg_we) begin
        blk_bytes <= cfg_data;
      end
      if (q_push && job.status == ST_OK) begin
        free_count <= free_count - FCW'(job.needed);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        bytes <= request_bytes;
        bs    <= bs_eff;
      end
      F_MUL: begin
        prod <= PW'(free_count) * PW'(bs);
      end
      F_CHECK: begin
        acc        <= '0;
        k          <= '0;
        job.status <= ST_NO_SPACE;
        job.needed <= '0;
      end
      F_COUNT: begin
        if (covered) begin
          job.status <= ST_OK;
          job.needed <= NEED_W'(k) + NEED_W'(1);
        end else if (at_limit) begin
          job.status <= ST_TOO_LARGE;
        end else begin
          acc <= acc + AW'(bs);
          k   <= k + KW'(1);
        end
      end
      F_PUSH: begin
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: sv/bba_queue.sv
module bba_queue import bba_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t pop_data
);

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = count == 2'd2;
  assign valid    = count != 2'd0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: sv/bba_back.sv
`include "bitmap_block_allocator_macros.svh"

module bba_back import bba_pkg::*; #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  job_t             q_data,
  output logic             q_pop,
  output logic             strobe,
  output logic [IDX_W-1:0] block_index,
  output logic             pointer_block,
  output logic [1:0]       status,
  output logic             last
);

  localparam int CW = $clog2(NUM_BLOCKS + 1);

  back_state_t       state, state_next;
  logic [CW-1:0]     next_free;
  logic [NEED_W-1:0] remain;
  status_t           cur_status;
  logic              first;
  logic              emit;
  logic              final_beat;
  logic              reject_beat;

  always_comb begin
    final_beat = (cur_status != ST_OK) || (remain == NEED_W'(1));
  end

  always_comb begin
    reject_beat = strobe && status != ST_OK;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (q_valid) state_next = B_EMIT;
      B_EMIT:  if (final_beat) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == B_IDLE) && q_valid;
    emit  = state == B_EMIT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      strobe    <= 1'b0;
      next_free <= '0;
    end else begin
      state  <= state_next;
      strobe <= emit;
      if (emit && cur_status == ST_OK) begin
        next_free <= next_free + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_status <= q_data.status;
      remain     <= q_data.needed;
      first      <= 1'b1;
    end else if (emit) begin
      remain <= remain - NEED_W'(1);
      first  <= 1'b0;
    end
    if (emit) begin
      status <= cur_status;
      last   <= final_beat;
      if (cur_status == ST_OK) begin
        block_index   <= IDX_W'(next_free);
        pointer_block <= first;
      end else begin
        block_index   <= '0;
        pointer_block <= 1'b0;
      end
    end
  end

  `BBA_ASSERT(a_reject_last, reject_beat, last, "rejection not last")
  `BBA_ASSERT(a_reject_idx, reject_beat, !(|block_index || pointer_block), "reject has block")
  `BBA_ASSERT_NEXT(a_burst, strobe && !last, strobe, "gap inside a burst")
  `BBA_ASSERT_NEXT(a_pop_emit, q_pop, strobe == 1'b0 && state == B_EMIT, "pop no burst")

endmodule

FILE: sv/bitmap_block_allocator.sv
// Block allocator for file storage, first fit from a next-free block counter.
// Input: raise start with request_bytes while busy is low; the beat is taken
// at that edge. Config: cfg_we with cfg_data writes the block size; the user
// must write only while idle, not enforced (0 acts as 1, above 4096 as 4096).
// Output: one beat per cycle on strobe with block_index, pointer_block,
// status and last. A granted request gives the pointer block, then its data
// blocks, lowest free index first; a rejection gives one beat, status 1 (no
// space) or 2 (more than MAX_BLOCKS_PER_REQUEST blocks).
// Busy: with C = ceil(bytes / block size), busy stays high from the start beat
// through the multiply and space check, then the add-and-compare count loop
// for a grant or a request over the limit (a rejection on space skips it), then
// the push into the two-entry queue to the back end, held while that is full.
// Once busy drops, the back end pops the entry when it is idle, enters its emit
// state and drives each beat onto strobe from a register.
// A grant of C + 1 blocks then gives C + 1 beats on back-to-back cycles;
// the back end returns to idle between entries, leaving a gap on strobe.
// The receiver cannot stall; beats are valid for exactly one cycle.
// Reset frees every block and sets the block size to 64; blocks are never
// released otherwise.
module bitmap_block_allocator import bba_pkg::*; #(
  parameter int NUM_BLOCKS             = 1024,
  parameter int MAX_BLOCKS_PER_REQUEST = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [BYTES_W-1:0] request_bytes,
  input  logic               cfg_we,
  input  logic [BS_W-1:0]    cfg_data,
  output logic               strobe,
  output logic [IDX_W-1:0]   block_index,
  output logic               pointer_block,
  output logic [1:0]         status,
  output logic               last
);

  logic q_push, q_full, q_pop, q_valid;
  job_t q_in, q_out;

  bba_front #(
    .NUM_BLOCKS(NUM_BLOCKS),
    .MAX_BLOCKS_PER_REQUEST(MAX_BLOCKS_PER_REQUEST)
  ) u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request_bytes(request_bytes), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .q_full(q_full), .q_push(q_push), .q_data(q_in)
  );

  bba_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .valid(q_valid), .pop_data(q_out)
  );

  bba_back #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_out), .q_pop(q_pop),
    .strobe(strobe), .block_index(block_index), .pointer_block(pointer_block),
    .status(status), .last(last)
  );

endmodule

FILE: test/tb_bitmap_block_allocator.sv
`timescale 1ns / 100ps

module tb_bitmap_block_allocator import bba_pkg::*;;

  localparam int NBLK      = 1024;
  localparam int MAX_REQ   = 64;
  localparam int LIMIT     = 3000000;
  localparam int SETTLE    = 40;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic             ptr;
    status_t          st;
    logic             lst;
  } grant_t;

  class alloc_scoreboard;
    bit [NBLK-1:0] used_map;
    int unsigned   free_blocks;
    int unsigned   bsize_reg;
    grant_t        pending[$];
    int            errors;

    function void clear();
      used_map    = '0;
      free_blocks = NBLK;
      bsize_reg   = BS_RESET;
      pending.delete();
      errors      = 0;
    endfunction

    function void set_bsize(logic [BS_W-1:0] v);
      bsize_reg = v;
    endfunction

    function void push(int unsigned i, bit p, status_t s, bit l);
      grant_t g;
      g.idx = i[IDX_W-1:0];
      g.ptr = p;
      g.st  = s;
      g.lst = l;
      pending.push_back(g);
    endfunction

    function void note_request(logic [BYTES_W-1:0] bytes);
      longint unsigned bs;
      longint unsigned need;
      int unsigned     got;
      bs = (bsize_reg == 0) ? 1 : (bsize_reg > BS_MAX) ? BS_MAX : bsize_reg;
      need = (longint'(bytes) + bs - 1) / bs + 1;
      got = 0;
      if (longint'(free_blocks) * bs < longint'(bytes) + bs)
        push(0, 0, ST_NO_SPACE, 1);
      else if (need > MAX_REQ)
        push(0, 0, ST_TOO_LARGE, 1);
      else begin
        for (int i = 0; i < NBLK && got < need; i++) begin
          if (!used_map[i]) begin
            used_map[i] = 1'b1;
            free_blocks--;
            push(i, got == 0, ST_OK, got + 1 == need);
            got++;
          end
        end
      end
    endfunction

    task report(string what);
      $display("mismatch @%0t: %s", $time, what);
      errors++;
    endtask

    task check_beat(logic [IDX_W-1:0] idx, logic ptr, logic [1:0] st, logic lst);
      grant_t g;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat idx=%0d st=%0d", idx, st));
      end else begin
        g = pending.pop_front();
        if (idx !== g.idx) report($sformatf("block_index %0d exp %0d", idx, g.idx));
        if (ptr !== g.ptr) report($sformatf("pointer_block %0b exp %0b", ptr, g.ptr));
        if (st !== g.st) report($sformatf("status %0d exp %0d", st, g.st));
        if (lst !== g.lst) report($sformatf("last %0b exp %0b", lst, g.lst));
      end
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [BYTES_W-1:0] request_bytes;
  logic               cfg_we;
  logic [BS_W-1:0]    cfg_data;
  logic               strobe;
  logic [IDX_W-1:0]   block_index;
  logic               pointer_block;
  logic [1:0]         status;
  logic               last;

  alloc_scoreboard sb;
  int unsigned     cycles;

  bitmap_block_allocator u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .request_bytes (request_bytes),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .strobe        (strobe),
    .block_index   (block_index),
    .pointer_block (pointer_block),
    .status        (status),
    .last          (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && strobe) sb.check_beat(block_index, pointer_block, status, last);
    if (cycles >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task send_request(logic [BYTES_W-1:0] bytes, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         <= 1'b1;
    request_bytes <= bytes;
    do @(posedge clk); while (busy);
    sb.note_request(bytes);
    @(negedge clk);
  endtask

  task drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task write_bsize(logic [BS_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    sb.set_bsize(v);
  endtask

  function automatic logic [BYTES_W-1:0] pick_bytes(int unsigned bs);
    int unsigned b;
    b = (bs == 0) ? 1 : (bs > BS_MAX) ? BS_MAX : bs;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return BYTES_W'($urandom);
      2:       return BYTES_W'(b * 63 + $urandom_range(0, 2 * b));
      3, 4:    return BYTES_W'($urandom_range(0, b * 4));
      default: return BYTES_W'($urandom_range(0, b * 20));
    endcase
  endfunction

  int unsigned bs_list[6] = '{64, 1, 4096, 0, 8191, 0};

  initial begin
    sb = new();
    sb.clear();
    cycles        = 0;
    rst           = 1'b1;
    start         = 1'b0;
    request_bytes = '0;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_request(0, 0);
    send_request(1, 0);
    send_request(64, $urandom_range(0, 7));
    send_request(65, 0);
    send_request(4032, $urandom_range(0, 7));
    send_request(4033, 0);
    send_request(20'hFFFFF, 0);
    send_request(20'h55555, 3);
    send_request(20'h2AAAA, 0);
    drain();

    bs_list[5] = $urandom_range(2, 8191);
    foreach (bs_list[p]) begin
      write_bsize(BS_W'(bs_list[p]));
      for (int n = 0; n < 67; n++)
        send_request(pick_bytes(bs_list[p]),
                     ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7));
      drain();
    end

    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
